// ----- rtl/substring_match_scanner_core_macros.svh -----
// Assertion shorthands for the substring match scanner.
`ifndef SUBSTRING_MATCH_SCANNER_CORE_MACROS_SVH
`define SUBSTRING_MATCH_SCANNER_CORE_MACROS_SVH

// Check that a condition holds in the same cycle as its trigger.
`define SMS_ASSERT_SAME(label, clock, rstn, ante, cons, msg) \
  label: assert property (@(posedge clock) disable iff (!rstn) (ante) |-> (cons)) \
    else $error(msg);

// Check that a condition holds in the cycle after its trigger.
`define SMS_ASSERT_NEXT(label, clock, rstn, ante, cons, msg) \
  label: assert property (@(posedge clock) disable iff (!rstn) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/sms_pkg.sv -----
package sms_pkg;

  // Configuration bus geometry: five registers, 64-bit data, 8-byte stride
  localparam int DATA_W    = 64;
  localparam int ADDR_W    = 6;
  localparam int REG_IDX_W = 3;

  // Field widths fixed by the interface
  localparam int LEN_W     = 5;
  localparam int OCC_W     = 16;
  localparam int OUT_POS_W = 16;
  localparam int CNT_W     = 16;

  typedef enum logic [REG_IDX_W-1:0] {
    REG_PATTERN_LOW  = 3'd0,
    REG_PATTERN_HIGH = 3'd1,
    REG_PATTERN_LEN  = 3'd2,
    REG_FOLD_CASE    = 3'd3,
    REG_OCCURRENCE   = 3'd4
  } sms_reg_t;

  // Map an ASCII upper-case letter to lower case when folding is on
  function automatic logic [7:0] sms_fold(input logic [7:0] c, input logic en);
    logic [7:0] res;
    res = c;
    if (en && (c >= 8'h41) && (c <= 8'h5A)) begin
      res = c + 8'h20;
    end
    return res;
  endfunction

endpackage

// ----- rtl/substring_match_scanner_core.sv -----
// Substring match scanner: streams a text one byte per request and counts every
// (overlapping) start of a configured pattern of 1 to PATTERN_MAX bytes, exact or
// ASCII case-folded. It takes one byte per clock, save for the stall below; the byte
// marked last yields one result request, passing through the input register and then
// the result register, carrying found flags, first/last/nth start, count and
// overflow. A last byte waits in the input register while an earlier result is
// still held on the output, which stalls the input for those cycles. All candidate
// bytes are compared combinationally between the input register and the
// state/result registers. Program the pattern, length, case folding and wanted
// occurrence through the APB port only while no text is in flight; positions
// beyond 2^POSITION_BITS bytes are dropped and flagged.
module substring_match_scanner_core
  import sms_pkg::*;
#(
  parameter int PATTERN_MAX   = 16,
  parameter int POSITION_BITS = 16
) (
  input  logic                  clk,
  input  logic                  rst_n,

  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [7:0]            in_text_byte,
  input  logic                  in_text_last,

  output logic                  out_valid,
  input  logic                  out_ready,
  output logic                  out_any_found,
  output logic [OUT_POS_W-1:0]  out_first_start,
  output logic [OUT_POS_W-1:0]  out_last_start,
  output logic                  out_nth_found,
  output logic [OUT_POS_W-1:0]  out_nth_start,
  output logic [CNT_W-1:0]      out_match_total,
  output logic                  out_length_overflow,

  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [ADDR_W-1:0]     paddr,
  input  logic [DATA_W-1:0]     pwdata,
  output logic [DATA_W-1:0]     prdata,
  output logic                  pready
);

`include "substring_match_scanner_core_macros.svh"

  localparam int POS_W  = POSITION_BITS + 1;
  localparam int WIN_D  = (PATTERN_MAX > 1) ? PATTERN_MAX - 1 : 1;
  localparam int CALC_W = (POS_W > OUT_POS_W) ? POS_W : OUT_POS_W;

  // Configuration registers
  logic [DATA_W-1:0] pat_lo_r;
  logic [DATA_W-1:0] pat_hi_r;
  logic [LEN_W-1:0]  pat_len_r;
  logic              fold_r;
  logic [OCC_W-1:0]  occ_r;

  // Input stage
  logic              in_valid_r;
  logic [7:0]        in_byte_r;
  logic              in_last_r;

  // Scan state
  logic [7:0]        recent_r [WIN_D];
  logic [POS_W-1:0]  pos_r,       pos_nxt;
  logic [CNT_W-1:0]  tally_r,     tally_nxt,     tally_upd;
  logic [OUT_POS_W-1:0] first_r,  first_nxt,     first_upd;
  logic [OUT_POS_W-1:0] latest_r, latest_nxt,    latest_upd;
  logic [OUT_POS_W-1:0] nth_r,    nth_nxt,       nth_upd;
  logic [OCC_W-1:0]  nth_left_r,  nth_left_nxt,  nth_left_upd;
  logic              any_r,       any_nxt,       any_upd;
  logic              nthf_r,      nthf_nxt,      nthf_upd;
  logic              ovf_r,       ovf_nxt,       ovf_upd;

  // Result register
  logic              out_valid_r;
  logic              res_any_r;
  logic [OUT_POS_W-1:0] res_first_r;
  logic [OUT_POS_W-1:0] res_last_r;
  logic              res_nthf_r;
  logic [OUT_POS_W-1:0] res_nth_r;
  logic [CNT_W-1:0]  res_total_r;
  logic              res_ovf_r;

  logic              cfg_wr;
  sms_reg_t          reg_idx;
  logic              proc;
  logic              overflowed;
  logic [LEN_W-1:0]  len_act;
  logic [LEN_W-1:0]  len_m1;
  logic [2*DATA_W-1:0] pat_all;
  logic [7:0]        pat_f [PATTERN_MAX];
  logic [7:0]        seq_f [PATTERN_MAX];
  logic [PATTERN_MAX-1:0] byte_ok;
  logic              in_window;
  logic              hit;
  logic [CALC_W-1:0] start_full;
  logic [OUT_POS_W-1:0] start;
  logic [OCC_W-1:0]  occ_load;

  // APB decode
  assign pready  = 1'b1;
  assign cfg_wr  = psel & penable & pwrite & pready;
  assign reg_idx = sms_reg_t'(paddr[ADDR_W-1:ADDR_W-REG_IDX_W]);

  always_comb begin
    unique case (reg_idx)
      REG_PATTERN_LOW:  prdata = pat_lo_r;
      REG_PATTERN_HIGH: prdata = pat_hi_r;
      REG_PATTERN_LEN:  prdata = DATA_W'(pat_len_r);
      REG_FOLD_CASE:    prdata = DATA_W'(fold_r);
      REG_OCCURRENCE:   prdata = DATA_W'(occ_r);
      default:          prdata = '0;
    endcase
  end

  // Advance the input stage unless a last byte would overwrite a stalled result
  assign proc     = in_valid_r & (~in_last_r | ~out_valid_r | out_ready);
  assign in_ready = ~in_valid_r | proc;

  // Clamp the pattern length into 1..PATTERN_MAX
  always_comb begin
    len_act = pat_len_r;
    if (pat_len_r == '0) begin
      len_act = LEN_W'(1);
    end else if (pat_len_r > LEN_W'(PATTERN_MAX)) begin
      len_act = LEN_W'(PATTERN_MAX);
    end
  end
  assign len_m1   = len_act - LEN_W'(1);
  assign occ_load = (occ_r == '0) ? OCC_W'(1) : occ_r;

  // Fold pattern and candidate bytes; seq_f[0] is the newest byte
  assign pat_all = {pat_hi_r, pat_lo_r};
  always_comb begin
    for (int j = 0; j < PATTERN_MAX; j++) begin
      pat_f[j] = sms_fold(pat_all[8*j +: 8], fold_r);
    end
    seq_f[0] = sms_fold(in_byte_r, fold_r);
    for (int j = 1; j < PATTERN_MAX; j++) begin
      seq_f[j] = sms_fold(recent_r[j-1], fold_r);
    end
  end

  // Pattern byte j lines up with the byte len-1-j places back
  always_comb begin
    for (int j = 0; j < PATTERN_MAX; j++) begin
      byte_ok[j] = (LEN_W'(j) >= len_act);
      for (int k = 0; k < PATTERN_MAX; k++) begin
        if (j + k < PATTERN_MAX) begin
          if (len_act == LEN_W'(j + k + 1)) begin
            byte_ok[j] = (pat_f[j] == seq_f[k]);
          end
        end
      end
    end
  end

  assign overflowed = pos_r[POS_W-1];
  assign in_window  = ~overflowed & (pos_r >= POS_W'(len_m1));
  assign hit        = in_window & (&byte_ok);
  assign start_full = CALC_W'(pos_r) + CALC_W'(1) - CALC_W'(len_act);
  assign start      = start_full[OUT_POS_W-1:0];

  // Update the scan state for the current byte
  always_comb begin
    tally_upd    = tally_r;
    first_upd    = first_r;
    latest_upd   = latest_r;
    nth_upd      = nth_r;
    nth_left_upd = nth_left_r;
    any_upd      = any_r;
    nthf_upd     = nthf_r;
    ovf_upd      = ovf_r | overflowed;
    if (hit) begin
      if (!any_r) begin
        first_upd = start;
      end
      latest_upd = start;
      any_upd    = 1'b1;
      if (tally_r != '1) begin
        tally_upd = tally_r + CNT_W'(1);
      end
      if (nth_left_r != '0) begin
        nth_left_upd = nth_left_r - OCC_W'(1);
        if (nth_left_r == OCC_W'(1)) begin
          nth_upd  = start;
          nthf_upd = 1'b1;
        end
      end
    end
  end

  // Next state: hold, update, clear after a last byte, or load a new occurrence
  always_comb begin
    pos_nxt      = pos_r;
    tally_nxt    = tally_r;
    first_nxt    = first_r;
    latest_nxt   = latest_r;
    nth_nxt      = nth_r;
    nth_left_nxt = nth_left_r;
    any_nxt      = any_r;
    nthf_nxt     = nthf_r;
    ovf_nxt      = ovf_r;
    if (proc) begin
      if (in_last_r) begin
        pos_nxt      = '0;
        tally_nxt    = '0;
        first_nxt    = '0;
        latest_nxt   = '0;
        nth_nxt      = '0;
        nth_left_nxt = occ_load;
        any_nxt      = 1'b0;
        nthf_nxt     = 1'b0;
        ovf_nxt      = 1'b0;
      end else begin
        pos_nxt      = overflowed ? pos_r : pos_r + POS_W'(1);
        tally_nxt    = tally_upd;
        first_nxt    = first_upd;
        latest_nxt   = latest_upd;
        nth_nxt      = nth_upd;
        nth_left_nxt = nth_left_upd;
        any_nxt      = any_upd;
        nthf_nxt     = nthf_upd;
        ovf_nxt      = ovf_upd;
      end
    end else if (cfg_wr && reg_idx == REG_OCCURRENCE && pos_r == '0) begin
      nth_left_nxt = (pwdata[OCC_W-1:0] == '0) ? OCC_W'(1) : pwdata[OCC_W-1:0];
    end
  end

  // Control and configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pat_lo_r    <= '0;
      pat_hi_r    <= '0;
      pat_len_r   <= LEN_W'(1);
      fold_r      <= 1'b0;
      occ_r       <= OCC_W'(1);
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      pos_r       <= '0;
      tally_r     <= '0;
      first_r     <= '0;
      latest_r    <= '0;
      nth_r       <= '0;
      nth_left_r  <= OCC_W'(1);
      any_r       <= 1'b0;
      nthf_r      <= 1'b0;
      ovf_r       <= 1'b0;
    end else begin
      if (cfg_wr) begin
        unique case (reg_idx)
          REG_PATTERN_LOW:  pat_lo_r  <= pwdata;
          REG_PATTERN_HIGH: pat_hi_r  <= pwdata;
          REG_PATTERN_LEN:  pat_len_r <= pwdata[LEN_W-1:0];
          REG_FOLD_CASE:    fold_r    <= pwdata[0];
          REG_OCCURRENCE:   occ_r     <= pwdata[OCC_W-1:0];
          default: ;
        endcase
      end
      if (in_ready) begin
        in_valid_r <= in_valid;
      end
      if (proc && in_last_r) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      pos_r      <= pos_nxt;
      tally_r    <= tally_nxt;
      first_r    <= first_nxt;
      latest_r   <= latest_nxt;
      nth_r      <= nth_nxt;
      nth_left_r <= nth_left_nxt;
      any_r      <= any_nxt;
      nthf_r     <= nthf_nxt;
      ovf_r      <= ovf_nxt;
    end
  end

  // Data path: input byte, window shift, result capture
  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      in_byte_r <= in_text_byte;
      in_last_r <= in_text_last;
    end
    if (proc && !overflowed) begin
      recent_r[0] <= in_byte_r;
      for (int i = 1; i < WIN_D; i++) begin
        recent_r[i] <= recent_r[i-1];
      end
    end
    if (proc && in_last_r) begin
      res_any_r   <= any_upd;
      res_first_r <= first_upd;
      res_last_r  <= latest_upd;
      res_nthf_r  <= nthf_upd;
      res_nth_r   <= nth_upd;
      res_total_r <= tally_upd;
      res_ovf_r   <= ovf_upd;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_any_found       = res_any_r;
  assign out_first_start     = res_first_r;
  assign out_last_start      = res_last_r;
  assign out_nth_found       = res_nthf_r;
  assign out_nth_start       = res_nth_r;
  assign out_match_total     = res_total_r;
  assign out_length_overflow = res_ovf_r;

  // Consistency checks
  `SMS_ASSERT_NEXT(a_last_gives_result, clk, rst_n, proc && in_last_r, out_valid_r, "no result")
  `SMS_ASSERT_SAME(a_no_hit_no_count, clk, rst_n, !any_r, tally_r == '0 && !nthf_r, "stray count")
  `SMS_ASSERT_SAME(a_ovf_saturated, clk, rst_n, ovf_r, pos_r[POS_W-1], "overflow below limit")

endmodule

// ----- verif/tb_substring_match_scanner_core.sv -----
module tb_substring_match_scanner_core;
  timeunit 1ns;
  timeprecision 1ps;

  import sms_pkg::*;

  localparam int          CLK_PERIOD    = 4;
  localparam int          PATTERN_MAX   = 16;
  localparam int          POSITION_BITS = 16;
  localparam int          WINDOW_DEPTH  = PATTERN_MAX - 1;
  localparam int unsigned POS_LIMIT     = 32'd1 << POSITION_BITS;
  localparam int          RANDOM_BYTES  = 1725;
  localparam int          LONG_TEXT_LEN = 65540;
  localparam int          SETTLE_CYCLES = 4;

  typedef struct packed {
    logic                 any_found;
    logic [OUT_POS_W-1:0] first_start;
    logic [OUT_POS_W-1:0] last_start;
    logic                 nth_found;
    logic [OUT_POS_W-1:0] nth_start;
    logic [CNT_W-1:0]     match_total;
    logic                 length_overflow;
  } scan_report_t;

  typedef enum int {ALPHA_FULL, ALPHA_MIXED, ALPHA_AB} alphabet_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic                 in_valid = 1'b0;
  logic                 in_ready;
  logic [7:0]           in_text_byte = '0;
  logic                 in_text_last = 1'b0;

  logic                 out_valid;
  logic                 out_ready = 1'b0;
  logic                 out_any_found;
  logic [OUT_POS_W-1:0] out_first_start;
  logic [OUT_POS_W-1:0] out_last_start;
  logic                 out_nth_found;
  logic [OUT_POS_W-1:0] out_nth_start;
  logic [CNT_W-1:0]     out_match_total;
  logic                 out_length_overflow;

  logic                 psel = 1'b0;
  logic                 penable = 1'b0;
  logic                 pwrite = 1'b0;
  logic [ADDR_W-1:0]    paddr = '0;
  logic [DATA_W-1:0]    pwdata = '0;
  logic [DATA_W-1:0]    prdata;
  logic                 pready;

  // Shadow of the configuration registers
  logic [63:0]    pat_lo = '0;
  logic [63:0]    pat_hi = '0;
  logic [LEN_W-1:0] pat_len = LEN_W'(1);
  logic           fold_en = 1'b0;
  logic [OCC_W-1:0] occ_want = OCC_W'(1);

  // Shadow of the per-text scan state
  logic [7:0]     window [WINDOW_DEPTH];
  int unsigned    text_pos = 0;
  logic [15:0]    hit_count = '0;
  logic [15:0]    first_hit = '0;
  logic [15:0]    last_hit = '0;
  logic [15:0]    nth_left = 16'd1;
  logic [15:0]    nth_pos = '0;
  logic           any_seen = 1'b0;
  logic           nth_seen = 1'b0;
  logic           overflow_seen = 1'b0;

  scan_report_t   expected_reports [$];

  // Run-wide knobs and tallies
  logic           rush = 1'b0;
  int             error_count = 0;
  int             reports_checked = 0;
  int             texts_sent = 0;
  int             bytes_sent = 0;

  substring_match_scanner_core #(
    .PATTERN_MAX  (PATTERN_MAX),
    .POSITION_BITS(POSITION_BITS)
  ) i_dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_text_byte       (in_text_byte),
    .in_text_last       (in_text_last),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_any_found      (out_any_found),
    .out_first_start    (out_first_start),
    .out_last_start     (out_last_start),
    .out_nth_found      (out_nth_found),
    .out_nth_start      (out_nth_start),
    .out_match_total    (out_match_total),
    .out_length_overflow(out_length_overflow),
    .psel               (psel),
    .penable            (penable),
    .pwrite             (pwrite),
    .paddr              (paddr),
    .pwdata             (pwdata),
    .prdata             (prdata),
    .pready             (pready)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  // ---------------------------------------------------------------------------
  // Scan predictor
  // ---------------------------------------------------------------------------

  // Lower-case an ASCII capital when folding is on
  function automatic logic [7:0] fold_char(input logic [7:0] c);
    if (fold_en && c >= 8'h41 && c <= 8'h5A) begin
      return c ^ 8'h20;
    end
    return c;
  endfunction

  function automatic logic [7:0] pattern_at(input int unsigned k);
    if (k < 8) begin
      return pat_lo[8*k +: 8];
    end
    return pat_hi[8*(k-8) +: 8];
  endfunction

  // Clamp the programmed length into 1..PATTERN_MAX
  function automatic int unsigned active_len();
    if (pat_len == 0) begin
      return 1;
    end
    if (pat_len > PATTERN_MAX) begin
      return PATTERN_MAX;
    end
    return pat_len;
  endfunction

  task automatic clear_scan();
    for (int k = 0; k < WINDOW_DEPTH; k++) begin
      window[k] = '0;
    end
    text_pos = 0;
    hit_count = '0;
    first_hit = '0;
    last_hit = '0;
    nth_pos = '0;
    any_seen = 1'b0;
    nth_seen = 1'b0;
    overflow_seen = 1'b0;
    nth_left = (occ_want == 0) ? 16'd1 : occ_want;
  endtask

  // Advance the scan by one accepted byte; queue a report on the last byte
  task automatic predict_scan_byte(input logic [7:0] b, input logic last);
    int unsigned  plen;
    logic         hit;
    logic [7:0]   seen;
    logic [15:0]  start;
    scan_report_t rep;
    if (text_pos >= POS_LIMIT) begin
      overflow_seen = 1'b1;
    end else begin
      plen = active_len();
      hit = (text_pos + 1 >= plen);
      for (int k = 0; k < plen; k++) begin
        if (k == 0) begin
          seen = b;
        end else begin
          seen = window[k-1];
        end
        if (fold_char(pattern_at(plen - 1 - k)) != fold_char(seen)) begin
          hit = 1'b0;
        end
      end
      if (hit) begin
        start = 16'(text_pos + 1 - plen);
        if (!any_seen) begin
          first_hit = start;
        end
        last_hit = start;
        any_seen = 1'b1;
        if (hit_count != 16'hFFFF) begin
          hit_count++;
        end
        if (nth_left != 0) begin
          nth_left--;
          if (nth_left == 0) begin
            nth_pos = start;
            nth_seen = 1'b1;
          end
        end
      end
      // shift the byte into the history window
      for (int k = WINDOW_DEPTH - 1; k > 0; k--) begin
        window[k] = window[k-1];
      end
      window[0] = b;
      text_pos++;
    end
    if (last) begin
      rep.any_found       = any_seen;
      rep.first_start     = first_hit;
      rep.last_start      = last_hit;
      rep.nth_found       = nth_seen;
      rep.nth_start       = nth_pos;
      rep.match_total     = hit_count;
      rep.length_overflow = overflow_seen;
      expected_reports.push_back(rep);
      clear_scan();
    end
  endtask

  // ---------------------------------------------------------------------------
  // Drivers
  // ---------------------------------------------------------------------------

  // Program one register over APB and mirror it in the shadow copy
  task automatic write_reg(input sms_reg_t idx, input logic [DATA_W-1:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= ADDR_W'(int'(idx) * 8);
    pwdata  <= val;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (pready !== 1'b1);
    psel    <= 1'b0;
    penable <= 1'b0;
    case (idx)
      REG_PATTERN_LOW:  pat_lo = val;
      REG_PATTERN_HIGH: pat_hi = val;
      REG_PATTERN_LEN:  pat_len = val[LEN_W-1:0];
      REG_FOLD_CASE:    fold_en = val[0];
      REG_OCCURRENCE: begin
        occ_want = val[OCC_W-1:0];
        if (text_pos == 0) begin
          nth_left = (occ_want == 0) ? 16'd1 : occ_want;
        end
      end
      default: ;
    endcase
    // idle the bus between transfers
    @(posedge clk);
  endtask

  task automatic program_all(input logic [63:0] lo, input logic [63:0] hi,
                             input int len, input logic fold, input int occ);
    write_reg(REG_PATTERN_LOW, lo);
    write_reg(REG_PATTERN_HIGH, hi);
    write_reg(REG_PATTERN_LEN, DATA_W'(len));
    write_reg(REG_FOLD_CASE, DATA_W'(fold));
    write_reg(REG_OCCURRENCE, DATA_W'(occ));
  endtask

  // Offer one byte request, optionally after an idle gap, and wait for acceptance
  task automatic send_byte(input logic [7:0] b, input logic last);
    int gap;
    gap = rush ? 0 : $urandom_range(0, 19);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_text_byte <= b;
    in_text_last <= last;
    do @(posedge clk); while (!(in_valid && in_ready === 1'b1));
    predict_scan_byte(b, last);
    bytes_sent++;
  endtask

  task automatic send_text(input logic [7:0] txt [$]);
    for (int i = 0; i < txt.size(); i++) begin
      send_byte(txt[i], i == txt.size() - 1);
    end
    texts_sent++;
  endtask

  // Drop valid, drain all pending reports and let the pipeline settle
  task automatic wait_quiet();
    in_valid <= 1'b0;
    while (expected_reports.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // ---------------------------------------------------------------------------
  // Result side
  // ---------------------------------------------------------------------------

  initial begin : result_sink
    int stall;
    forever begin
      stall = rush ? 0 : $urandom_range(0, 19);
      if (stall != 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!(out_valid === 1'b1 && out_ready));
    end
  end

  task automatic flag_error(input string msg);
    $display("ERROR at %0t ns: %s", $time, msg);
    error_count++;
  endtask

  task automatic check_field(input string name, input logic [31:0] got,
                             input logic [31:0] want);
    if (got !== want) begin
      flag_error($sformatf("%s got 0x%0h, expected 0x%0h", name, got, want));
    end
  endtask

  // Compare every accepted report against the oldest prediction
  always @(posedge clk) begin
    scan_report_t want;
    if (rst_n && out_valid === 1'b1 && out_ready) begin
      if (expected_reports.size() == 0) begin
        flag_error("report received with no text pending");
      end else begin
        want = expected_reports.pop_front();
        reports_checked++;
        check_field("any_found", 32'(out_any_found), 32'(want.any_found));
        check_field("first_start", 32'(out_first_start), 32'(want.first_start));
        check_field("last_start", 32'(out_last_start), 32'(want.last_start));
        check_field("nth_found", 32'(out_nth_found), 32'(want.nth_found));
        check_field("nth_start", 32'(out_nth_start), 32'(want.nth_start));
        check_field("match_total", 32'(out_match_total), 32'(want.match_total));
        check_field("length_overflow", 32'(out_length_overflow),
                    32'(want.length_overflow));
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Default registers: a zero byte matches the all-zero pattern of length one
  task automatic test_reset_pattern();
    send_text('{8'h00});
    wait_quiet();
  endtask

  // Overlapping starts of "aa" inside "aaaa", then a text shorter than the pattern
  task automatic test_overlap_and_short();
    program_all(64'h6161, 64'h0, 2, 1'b0, 2);
    send_text('{8'h61, 8'h61, 8'h61, 8'h61});
    send_text('{8'h61});
    wait_quiet();
  endtask

  // Mixed case matches only with folding on
  task automatic test_case_fold();
    program_all(64'h4261, 64'h0, 2, 1'b1, 1);
    send_text('{8'h41, 8'h62});
    wait_quiet();
    write_reg(REG_FOLD_CASE, DATA_W'(0));
    send_text('{8'h41, 8'h62});
    wait_quiet();
  endtask

  // Length zero acts as one, occurrence zero as one; oversize length clamps to 16
  task automatic test_length_limits();
    logic [7:0] txt [$];
    program_all(64'h61, 64'h0, 0, 1'b0, 0);
    send_text('{8'h61});
    wait_quiet();
    program_all(64'h807F_FF00_55AA_0FF0, 64'h0102_0408_1020_40FE, 31, 1'b0, 1);
    for (int k = 0; k < PATTERN_MAX; k++) begin
      txt.push_back(pattern_at(k));
    end
    send_text(txt);
    wait_quiet();
  endtask

  // Run past the position range: saturated count, dropped tail, overflow flag
  task automatic test_long_text();
    program_all(64'h61, 64'h0, 1, 1'b0, 65535);
    rush = 1'b1;
    for (int i = 0; i < LONG_TEXT_LEN; i++) begin
      send_byte(8'h61, i == LONG_TEXT_LEN - 1);
    end
    texts_sent++;
    rush = 1'b0;
    wait_quiet();
  endtask

  function automatic logic [7:0] pick_symbol(input alphabet_t mode);
    logic [7:0] mixed_set [8] = '{8'h61, 8'h41, 8'h62, 8'h42, 8'h40, 8'h5B, 8'h60, 8'h7B};
    case (mode)
      ALPHA_MIXED: begin
        if ($urandom_range(0, 9) == 0) begin
          return 8'($urandom_range(0, 255));
        end
        return mixed_set[$urandom_range(0, 7)];
      end
      ALPHA_AB: return ($urandom_range(0, 1) == 0) ? 8'h61 : 8'h62;
      default:  return 8'($urandom_range(0, 255));
    endcase
  endfunction

  // Flip the case of a letter now and then
  function automatic logic [7:0] jitter_case(input logic [7:0] c);
    logic [7:0] low;
    low = c | 8'h20;
    if (low >= 8'h61 && low <= 8'h7A && $urandom_range(0, 3) == 0) begin
      return c ^ 8'h20;
    end
    return c;
  endfunction

  // Random registers, then texts seeded with whole and partial pattern copies
  task automatic test_random_texts();
    int          start_bytes;
    int          r;
    int          len;
    int          occ;
    int          n_texts;
    int          tlen;
    int          copy_len;
    int unsigned plen;
    logic [63:0] lo;
    logic [63:0] hi;
    alphabet_t   mode;
    logic [7:0]  txt [$];
    start_bytes = bytes_sent;
    while (bytes_sent - start_bytes < RANDOM_BYTES) begin
      mode = alphabet_t'($urandom_range(0, 2));
      for (int k = 0; k < 8; k++) begin
        lo[8*k +: 8] = pick_symbol(mode);
        hi[8*k +: 8] = pick_symbol(mode);
      end
      r = $urandom_range(0, 19);
      if (r == 0) begin
        lo = '0;
        hi = '0;
      end else if (r == 1) begin
        lo = '1;
        hi = '1;
      end
      r = $urandom_range(0, 9);
      if (r <= 5) begin
        len = $urandom_range(1, 3);
      end else if (r <= 7) begin
        len = $urandom_range(4, 16);
      end else if (r == 8) begin
        len = $urandom_range(17, 31);
      end else begin
        len = 0;
      end
      r = $urandom_range(0, 7);
      occ = (r == 0) ? 0 : (r == 1) ? 65535 : $urandom_range(1, 4);
      program_all(lo, hi, len, 1'($urandom_range(0, 1)), occ);
      plen = active_len();

      n_texts = $urandom_range(1, 6);
      for (int t = 0; t < n_texts; t++) begin
        txt.delete();
        tlen = ($urandom_range(0, 19) == 0) ? $urandom_range(41, 120)
                                            : $urandom_range(1, 30);
        while (txt.size() < tlen) begin
          if ($urandom_range(0, 2) == 0) begin
            // whole copy most of the time, a broken prefix otherwise
            copy_len = ($urandom_range(0, 3) == 0) ? $urandom_range(1, plen) : plen;
            for (int k = 0; k < copy_len; k++) begin
              txt.push_back(jitter_case(pattern_at(k)));
            end
          end else begin
            txt.push_back(pick_symbol(mode));
          end
        end
        rush = ($urandom_range(0, 3) == 0);
        send_text(txt);
      end
      rush = 1'b0;
      wait_quiet();
    end
  endtask

  initial begin
    clear_scan();
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_reset_pattern();
    test_overlap_and_short();
    test_case_fold();
    test_length_limits();
    test_long_text();
    test_random_texts();
    wait_quiet();

    $display("Scanned %0d texts, %0d bytes, one past the position range", texts_sent,
             bytes_sent);
    $display("Checked %0d reports, %0d mismatches", reports_checked, error_count);
    if (error_count == 0 && expected_reports.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  // Hard stop if the handshakes hang
  initial begin
    #4_000_000;
    $display("Timed out with %0d reports pending", expected_reports.size());
    $display("FAIL");
    $finish;
  end

endmodule
